// File: rtl/core/fnpc_pkg.sv
`default_nettype none
package fnpc_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int PITCH_W    = 14;
    localparam int NOTE_W     = 7;
    localparam int CUTOFF_W   = 19;
    localparam int HELD_W     = 5;
    localparam int RATIO_W    = 17;
    localparam int PROD_W     = PITCH_W + RATIO_W;
    localparam int SHIFT_W    = 5;

    localparam logic [PITCH_W-1:0]  PITCH_RESET  = PITCH_W'(7040);
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = CUTOFF_W'(8000);
    localparam logic [CUTOFF_W-1:0] CUTOFF_MAX   = {CUTOFF_W{1'b1}};

    // note number offset so that note 69 lands on the ratio of one
    localparam int NOTE_OFFSET = 3;
    localparam int SEMITONES   = 12;
    localparam int SHIFT_BASE  = 22;

    typedef enum logic {
        OP_NOTE_OFF = 1'b0,
        OP_NOTE_ON  = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [NOTE_W-1:0]   note_number;
    } in_item_t;

    typedef struct packed {
        logic [CUTOFF_W-1:0] cutoff_freq;
        logic                wet_active;
        logic [HELD_W-1:0]   held_count;
        logic                overflow;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOOKUP,
        ST_PITCH,
        ST_FINISH
    } state_t;

    // 2^(k/12) in unsigned Q1.16, rounded to nearest
    function automatic logic [RATIO_W-1:0] semitone_ratio(input logic [3:0] k);
        logic [RATIO_W-1:0] r;
        begin
            unique case (k)
                4'd0:    r = RATIO_W'(65536);
                4'd1:    r = RATIO_W'(69433);
                4'd2:    r = RATIO_W'(73562);
                4'd3:    r = RATIO_W'(77936);
                4'd4:    r = RATIO_W'(82570);
                4'd5:    r = RATIO_W'(87480);
                4'd6:    r = RATIO_W'(92682);
                4'd7:    r = RATIO_W'(98193);
                4'd8:    r = RATIO_W'(104032);
                4'd9:    r = RATIO_W'(110218);
                4'd10:   r = RATIO_W'(116772);
                4'd11:   r = RATIO_W'(123715);
                default: r = RATIO_W'(65536);
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/fnpc_ram.sv
`default_nettype none
module fnpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/fnpc_pitch.sv
`default_nettype none
module fnpc_pitch (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [fnpc_pkg::NOTE_W-1:0]   note,
    input  wire logic [fnpc_pkg::PITCH_W-1:0]  pitch,
    output logic                               done,
    output logic      [fnpc_pkg::CUTOFF_W-1:0] cutoff
);
    import fnpc_pkg::*;

    // floor(m / 12) as (m * 171) >> 11, exact for m below 512
    localparam int RECIP_12 = 171;
    localparam int RECIP_SH = 11;

    logic [7:0]          m;
    logic [15:0]         q_prod;
    logic [3:0]          q;
    logic [3:0]          k;
    logic [SHIFT_W-1:0]  s;
    logic [PROD_W-1:0]   prod_reg;
    logic [SHIFT_W-1:0]  shift_reg;
    logic                v1_reg;
    logic [PROD_W:0]     rounded;
    logic [PROD_W:0]     val;
    logic                done_reg;
    logic [CUTOFF_W-1:0] cutoff_reg;

    assign m      = 8'(note) + 8'(NOTE_OFFSET);
    assign q_prod = 16'(m) * 16'(RECIP_12);
    assign q      = 4'(q_prod >> RECIP_SH);
    assign k      = 4'(m - 8'(q) * 8'(SEMITONES));
    assign s      = SHIFT_W'(SHIFT_BASE) - SHIFT_W'(q);

    // stage 1: multiply by the semitone ratio
    always_ff @(posedge clk)
    begin
        prod_reg  <= PROD_W'(pitch) * PROD_W'(semitone_ratio(k));
        shift_reg <= s;
    end

    // stage 2: round half up, scale by octave, saturate
    assign rounded = {1'b0, prod_reg} + ((PROD_W+1)'(1) << (shift_reg - SHIFT_W'(1)));
    assign val     = rounded >> shift_reg;

    always_ff @(posedge clk)
    begin
        if (val > (PROD_W+1)'(CUTOFF_MAX))
        begin
            cutoff_reg <= CUTOFF_MAX;
        end
        else
        begin
            cutoff_reg <= CUTOFF_W'(val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
    end

    assign done   = done_reg;
    assign cutoff = cutoff_reg;

endmodule
`default_nettype wire

// File: rtl/core/first_note_priority_cutoff.sv
// From input to result: an overflow, a note-on behind held notes or a note-off on
// an empty list go straight to the result; a note-on into an empty list runs the
// pitch unit; a note-off compacts the list and, if notes remain, looks up the new
// head and runs the pitch unit. Compaction walks the held-note RAM one entry per
// cycle; the next input is taken the cycle after the result is registered.
// Reset (rst_n, async low): list empty, cutoff 8000, wet flag low, pitch 7040.
`default_nettype none
module first_note_priority_cutoff #(
    parameter int DEPTH = fnpc_pkg::DEPTH_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire fnpc_pkg::in_item_t           in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output fnpc_pkg::out_item_t               out_data,
    input  wire logic                         cfg_we,
    input  wire logic [fnpc_pkg::PITCH_W-1:0] cfg_wdata
);
    import fnpc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    state_t              state_reg, state_next;
    logic [PITCH_W-1:0]  pitch_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [CUTOFF_W-1:0] cutoff_reg, cutoff_next;
    logic                wet_reg, wet_next;
    logic                ovf_reg, ovf_next;
    logic [NOTE_W-1:0]   note_reg, note_next;
    logic [NOTE_W-1:0]   head_reg, head_next;
    logic [AW-1:0]       rd_idx_reg, rd_idx_next;
    logic [CW-1:0]       wr_idx_reg, wr_idx_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_reg, out_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [NOTE_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [NOTE_W-1:0]   ram_rdata;

    logic                pitch_start;
    logic [NOTE_W-1:0]   pitch_note;
    logic                pitch_done;
    logic [CUTOFF_W-1:0] pitch_cutoff;

    logic                scan_last;
    logic                keep;

    fnpc_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (DEPTH)
    ) u_held_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    fnpc_pitch u_pitch (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (pitch_start),
        .note   (pitch_note),
        .pitch  (pitch_reg),
        .done   (pitch_done),
        .cutoff (pitch_cutoff)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pitch_reg     <= PITCH_RESET;
            count_reg     <= '0;
            cutoff_reg    <= CUTOFF_RESET;
            wet_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cutoff_reg    <= cutoff_next;
            wet_reg       <= wet_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                pitch_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg    <= ovf_next;
        note_reg   <= note_next;
        head_reg   <= head_next;
        rd_idx_reg <= rd_idx_next;
        wr_idx_reg <= wr_idx_next;
        out_reg    <= out_next;
    end

    assign scan_last = (CW'(rd_idx_reg) + CW'(1)) == count_reg;
    assign keep      = ram_rdata != note_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cutoff_next    = cutoff_reg;
        wet_next       = wet_reg;
        ovf_next       = ovf_reg;
        note_next      = note_reg;
        head_next      = head_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        in_ready    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[AW-1:0];
        ram_wdata   = in_data.note_number;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        pitch_start = 1'b0;
        pitch_note  = in_data.note_number;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    note_next   = in_data.note_number;
                    ovf_next    = 1'b0;
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    if (in_data.opcode == OP_NOTE_ON)
                    begin
                        wet_next = 1'b1;
                        if (count_reg >= CW'(DEPTH))
                        begin
                            ovf_next   = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (count_reg == '0)
                            begin
                                pitch_start = 1'b1;
                                state_next  = ST_PITCH;
                            end
                            else
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        wet_next   = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // prefetch the oldest entry
                        ram_re     = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // compact in place: write index never passes read index
                ram_raddr = rd_idx_reg + AW'(1);
                ram_re    = !scan_last;
                ram_waddr = wr_idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
                ram_we    = keep;
                if (keep)
                begin
                    wr_idx_next = wr_idx_reg + CW'(1);
                    if (wr_idx_reg == '0)
                    begin
                        head_next = ram_rdata;
                    end
                end
                rd_idx_next = rd_idx_reg + AW'(1);
                if (scan_last)
                begin
                    count_next = wr_idx_next;
                    if (wr_idx_next == '0)
                    begin
                        wet_next   = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            end

            ST_LOOKUP:
            begin
                pitch_start = 1'b1;
                pitch_note  = head_reg;
                state_next  = ST_PITCH;
            end

            ST_PITCH:
            begin
                if (pitch_done)
                begin
                    cutoff_next = pitch_cutoff;
                    state_next  = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next       = 1'b1;
                    out_next.cutoff_freq = cutoff_reg;
                    out_next.wet_active  = wet_reg;
                    out_next.held_count  = HELD_W'(count_reg);
                    out_next.overflow    = ovf_reg;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire
